/* design/npm_pkg.sv */
// Shared types and constants of the noisy pixel masker.
package npm_pkg;

    localparam int ACT_W      = 2;
    localparam int COORD_W    = 12;
    localparam int CFG_DIM_W  = 9;
    localparam int DIM_W      = 12;
    localparam int THR_W      = 16;
    localparam int TOTAL_W    = 32;
    localparam int MASKED_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACT_W-1:0] ACT_COUNT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FILTER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    localparam logic [CFG_DIM_W-1:0] GRID_COLS_RESET = 9'd256;
    localparam logic [CFG_DIM_W-1:0] GRID_ROWS_RESET = 9'd256;
    localparam logic [THR_W-1:0]     THRESHOLD_RESET = 16'd2560;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] hit_column;
        logic [COORD_W-1:0] hit_row;
    } npm_in_t;

    typedef struct packed {
        logic                kept;
        logic                out_of_range;
        logic [MASKED_W-1:0] masked_total;
    } npm_out_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic               oor;
        logic [COORD_W-1:0] hit_column;
        logic [COORD_W-1:0] hit_row;
    } npm_cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] cols;
        logic [DIM_W-1:0] rows;
        logic [THR_W-1:0] threshold_q;
    } npm_cfg_t;

endpackage

/* design/noisy_pixel_masker_core.sv */
// Top level of the noisy pixel masker: front end, command queue and back end.
//
//  channel | handshake                | payload                        | direction
//  --------+--------------------------+--------------------------------+----------
//  cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data            | in
//  item    | item_valid / item_ready  | item (action, column, row)     | in
//  result  | result_valid / result_ready | result (kept, oor, masked)  | out
//
// A count or filter transaction passes through the back end as a memory read, then a
// write or decision; the count memory's read-then-write port sets that order.
// A build transaction sweeps every pixel address.
// After reset a clearing pass over every pixel address zeroes both memories;
// item_ready stays low during it while configuration writes are still taken.
// A stalled result holds in the output register; up to two items queue behind it.
module noisy_pixel_masker_core #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int COUNT_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [npm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [npm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  npm_pkg::npm_in_t               item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output npm_pkg::npm_out_t              result
);
    import npm_pkg::*;

    npm_cfg_t cfg_eff;
    npm_cmd_t front_cmd;
    npm_cmd_t back_cmd;
    logic     front_valid;
    logic     front_ready;
    logic     back_valid;
    logic     back_ready;
    logic     clear_busy;

    npm_front #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .clear_busy(clear_busy),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd),
        .cfg_eff   (cfg_eff)
    );

    npm_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (front_valid),
        .in_ready (front_ready),
        .in_cmd   (front_cmd),
        .out_valid(back_valid),
        .out_ready(back_ready),
        .out_cmd  (back_cmd)
    );

    npm_back #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_eff     (cfg_eff),
        .cmd_valid   (back_valid),
        .cmd_ready   (back_ready),
        .cmd         (back_cmd),
        .clear_busy  (clear_busy),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

/* design/npm_front.sv */
// Front end: configuration registers, grid clamping and hit classification.
module npm_front #(
    parameter int MAX_COLS = 256,
    parameter int MAX_ROWS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [npm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [npm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  npm_pkg::npm_in_t                     item,
    input  logic                                 clear_busy,
    output logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    output npm_pkg::npm_cmd_t                    cmd,
    output npm_pkg::npm_cfg_t                    cfg_eff
);
    import npm_pkg::*;

    localparam logic [DIM_W-1:0] MAX_C = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] MAX_R = DIM_W'(MAX_ROWS);

    logic [CFG_DIM_W-1:0] cols_reg, cols_next;
    logic [CFG_DIM_W-1:0] rows_reg, rows_next;
    logic [THR_W-1:0]     thr_reg, thr_next;
    logic [DIM_W-1:0]     cols_eff;
    logic [DIM_W-1:0]     rows_eff;

    // A zero dimension acts as one, and anything above the array size as that size.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(v);
        if (ext == '0)
            return DIM_W'(1);
        return (ext > maxv) ? maxv : ext;
    endfunction

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        thr_next  = thr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GRID_COLS: cols_next = cfg_data[CFG_DIM_W-1:0];
                REG_GRID_ROWS: rows_next = cfg_data[CFG_DIM_W-1:0];
                REG_THRESHOLD: thr_next  = cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= GRID_COLS_RESET;
            rows_reg <= GRID_ROWS_RESET;
            thr_reg  <= THRESHOLD_RESET;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            thr_reg  <= thr_next;
        end
    end

    assign cols_eff = clamp_dim(cols_reg, MAX_C);
    assign rows_eff = clamp_dim(rows_reg, MAX_R);

    assign cfg_eff.cols        = cols_eff;
    assign cfg_eff.rows        = rows_eff;
    assign cfg_eff.threshold_q = thr_reg;

    assign item_ready = !clear_busy && cmd_ready;
    assign cmd_valid  = item_valid && !clear_busy;

    assign cmd.action     = item.action;
    assign cmd.oor        = (item.hit_column >= cols_eff) || (item.hit_row >= rows_eff);
    assign cmd.hit_column = item.hit_column;
    assign cmd.hit_row    = item.hit_row;

endmodule

/* design/npm_queue.sv */
// Short command queue between the front end and the back end.
module npm_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  npm_pkg::npm_cmd_t in_cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output npm_pkg::npm_cmd_t out_cmd
);
    import npm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    npm_cmd_t         entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

/* design/npm_back.sv */
// Back end: pixel count and mark memories, clearing pass, mask sweep and result register.
module npm_back #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int COUNT_BITS = 20
) (
    input  logic              clk,
    input  logic              rst_n,
    input  npm_pkg::npm_cfg_t cfg_eff,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  npm_pkg::npm_cmd_t cmd,
    output logic              clear_busy,
    output logic              result_valid,
    input  logic              result_ready,
    output npm_pkg::npm_out_t result
);
    import npm_pkg::*;

    localparam int PIXELS  = MAX_COLS * MAX_ROWS;
    localparam int AW      = $clog2(PIXELS);
    localparam int XW      = $clog2(MAX_COLS);
    localparam int YW      = $clog2(MAX_ROWS);
    localparam int AREA_W  = $clog2(PIXELS + 1);
    localparam int PROD_W  = COUNT_BITS + AREA_W;
    localparam int SHIFT   = 8;
    localparam int LIMIT_W = TOTAL_W + THR_W;
    localparam int CMP_W   = (PROD_W + SHIFT > LIMIT_W) ? PROD_W + SHIFT : LIMIT_W;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_COUNT  = 3'd2;
    localparam logic [2:0] ST_FILTER = 3'd3;
    localparam logic [2:0] ST_SWEEP  = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;

    localparam logic [AW-1:0]         LAST_ADDR = AW'(PIXELS - 1);
    localparam logic [YW-1:0]         LAST_Y    = YW'(MAX_ROWS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [MASKED_W-1:0]   MASK_MAX  = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

    logic [COUNT_BITS-1:0] count_mem [PIXELS];
    logic                  mark_mem  [PIXELS];

    logic [2:0]            state_reg, state_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [XW-1:0]         x_reg, x_next;
    logic [YW-1:0]         y_reg, y_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;
    logic                  s1_v_reg, s1_v_next;
    logic                  s2_v_reg, s2_v_next;
    logic                  res_valid_reg, res_valid_next;

    logic                  op_oor_reg, op_oor_next;
    logic [AW-1:0]         op_addr_reg, op_addr_next;
    logic [AREA_W-1:0]     area_reg, area_next;
    logic [LIMIT_W-1:0]    limit_reg, limit_next;
    logic                  s1_in_reg, s1_in_next;
    logic [AW-1:0]         s1_addr_reg, s1_addr_next;
    logic                  s2_in_reg, s2_in_next;
    logic [AW-1:0]         s2_addr_reg, s2_addr_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [MASKED_W-1:0]   masked_reg, masked_next;
    npm_out_t              res_reg, res_next;
    logic [COUNT_BITS-1:0] count_rd_reg;
    logic                  mark_rd_reg;

    logic [AW-1:0]         item_addr;
    logic                  res_free;
    logic                  noisy;
    logic [2*DIM_W-1:0]    area_full;
    logic                  cnt_we;
    logic [AW-1:0]         cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [AW-1:0]         cnt_raddr;
    logic                  mark_we;
    logic [AW-1:0]         mark_waddr;
    logic                  mark_wdata;

    // Pixel address is column * MAX_ROWS + row; only meaningful for in-grid hits.
    assign item_addr = AW'(cmd.hit_column[XW-1:0]) * AW'(MAX_ROWS)
                     + AW'(cmd.hit_row[YW-1:0]);

    assign res_free   = !res_valid_reg || result_ready;
    assign area_full  = cfg_eff.cols * cfg_eff.rows;
    assign noisy      = s2_in_reg
                     && (CMP_W'({prod_reg, {SHIFT{1'b0}}}) > CMP_W'(limit_reg));
    assign clear_busy = (state_reg == ST_CLEAR);
    assign cnt_raddr  = (state_reg == ST_SWEEP) ? addr_reg : item_addr;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        total_next     = total_reg;
        res_valid_next = res_valid_reg;
        op_oor_next    = op_oor_reg;
        op_addr_next   = op_addr_reg;
        area_next      = area_reg;
        limit_next     = limit_reg;
        masked_next    = masked_reg;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        cnt_we         = 1'b0;
        cnt_waddr      = op_addr_reg;
        cnt_wdata      = '0;
        mark_we        = 1'b0;
        mark_waddr     = s2_addr_reg;
        mark_wdata     = 1'b0;

        // Sweep pipeline: read count, multiply by grid area, compare and write mark.
        s1_v_next    = 1'b0;
        s1_in_next   = s1_in_reg;
        s1_addr_next = s1_addr_reg;
        s2_v_next    = s1_v_reg;
        s2_in_next   = s1_in_reg;
        s2_addr_next = s1_addr_reg;
        prod_next    = count_rd_reg * area_reg;
        if (s2_v_reg)
        begin
            mark_we    = 1'b1;
            mark_wdata = noisy;
            if (noisy && masked_reg != MASK_MAX)
                masked_next = masked_reg + 1'b1;
        end

        if (res_valid_reg && result_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_we     = 1'b1;
                cnt_waddr  = addr_reg;
                mark_we    = 1'b1;
                mark_waddr = addr_reg;
                mark_wdata = 1'b0;
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                    addr_next = addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (cmd_valid && res_free)
                begin
                    cmd_ready    = 1'b1;
                    op_oor_next  = cmd.oor;
                    op_addr_next = item_addr;
                    unique case (cmd.action)
                        ACT_COUNT:
                        begin
                            if (total_reg != TOTAL_MAX)
                                total_next = total_reg + 1'b1;
                            state_next = ST_COUNT;
                        end
                        ACT_FILTER:
                            state_next = ST_FILTER;
                        ACT_BUILD:
                        begin
                            area_next   = AREA_W'(area_full);
                            limit_next  = total_reg * cfg_eff.threshold_q;
                            addr_next   = '0;
                            x_next      = '0;
                            y_next      = '0;
                            masked_next = '0;
                            state_next  = ST_SWEEP;
                        end
                        default:
                        begin
                            res_next       = '0;
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_COUNT:
            begin
                if (!op_oor_reg)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = (count_rd_reg == COUNT_MAX) ? count_rd_reg
                                                            : count_rd_reg + 1'b1;
                end
                res_next.kept         = 1'b0;
                res_next.out_of_range = op_oor_reg;
                res_next.masked_total = '0;
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_FILTER:
            begin
                res_next.kept         = !op_oor_reg && !mark_rd_reg;
                res_next.out_of_range = op_oor_reg;
                res_next.masked_total = '0;
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
            end
            ST_SWEEP:
            begin
                s1_v_next    = 1'b1;
                s1_addr_next = addr_reg;
                s1_in_next   = (DIM_W'(x_reg) < cfg_eff.cols) && (DIM_W'(y_reg) < cfg_eff.rows);
                if (y_reg == LAST_Y)
                begin
                    y_next = '0;
                    x_next = x_reg + 1'b1;
                end
                else
                    y_next = y_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                    state_next = ST_DRAIN;
                else
                    addr_next = addr_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    res_next.kept         = 1'b0;
                    res_next.out_of_range = 1'b0;
                    res_next.masked_total = masked_reg;
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            total_reg     <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            total_reg     <= total_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_oor_reg  <= op_oor_next;
        op_addr_reg <= op_addr_next;
        area_reg    <= area_next;
        limit_reg   <= limit_next;
        s1_in_reg   <= s1_in_next;
        s1_addr_reg <= s1_addr_next;
        s2_in_reg   <= s2_in_next;
        s2_addr_reg <= s2_addr_next;
        prod_reg    <= prod_next;
        masked_reg  <= masked_next;
        res_reg     <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            count_mem[cnt_waddr] <= cnt_wdata;
        count_rd_reg <= count_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_waddr] <= mark_wdata;
        mark_rd_reg <= mark_mem[item_addr];
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

/* design/npm_checker.sv */
// Port-level checker for the noisy pixel masker, bound to the top level.
module npm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input npm_pkg::npm_out_t result
);
    import npm_pkg::*;

    // A stalled result must hold until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed or dropped while stalled");

    // A kept hit is always inside the grid.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.kept && result.out_of_range))
        else $error("hit reported both kept and out of range");

    // Only a build transaction reports a mask total, and it carries no hit flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.masked_total != '0) |-> !result.kept && !result.out_of_range)
        else $error("mask total mixed with hit flags");

    // The clearing pass after reset holds off new items.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !item_ready)
        else $error("item accepted before the clearing pass");

endmodule

bind noisy_pixel_masker_core npm_checker u_npm_checker (.*);
